// ----- hw/rtl/lppd_pkg.sv -----
`default_nettype none
package lppd_pkg;

  localparam int unsigned HdrBytes   = 12;
  localparam int unsigned LenBytes   = 4;
  localparam int unsigned CntWidth   = 4;
  localparam int unsigned LimitWidth = 21;
  localparam logic [LimitWidth-1:0] LimitReset = 21'd8192;

  localparam logic [CntWidth-1:0] PosHdrEnd = CntWidth'(HdrBytes);
  localparam logic [CntWidth-1:0] PosLenEnd = CntWidth'(LenBytes - 1);
  localparam logic [CntWidth-1:0] PosLast   = CntWidth'(HdrBytes - 1);
  localparam logic [31:0]         HdrLen    = 32'(HdrBytes);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_LEN = 2'd2,
    KIND_SHORT   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] main_id;
    logic [15:0] sub_id;
    logic [31:0] flag;
    logic [31:0] length;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lppd_front.sv -----
`default_nettype none
module lppd_front
  import lppd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  stream_valid_i,
  output logic                       stream_ready_o,
  input  wire logic [7:0]            stream_byte_i,
  input  wire logic [LimitWidth-1:0] limit_i,
  input  wire logic                  q_ready_i,
  output logic                       q_push_o,
  output res_t                       q_data_o
);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [15:0] main_q, main_d;
  logic [15:0] sub_q, sub_d;
  logic [31:0] flag_q, flag_d;
  logic [31:0] left_q, left_d;
  logic        accept;

  assign stream_ready_o = q_ready_i;
  assign accept = stream_valid_i & q_ready_i;

  always_comb begin
    cnt_d  = cnt_q;
    len_d  = len_q;
    main_d = main_q;
    sub_d  = sub_q;
    flag_d = flag_q;
    left_d = left_q;
    q_push_o = 1'b0;
    q_data_o.kind = KIND_PAYLOAD;
    q_data_o.data = stream_byte_i;
    q_data_o.last = 1'b0;
    if (accept) begin
      if (cnt_q >= PosHdrEnd) begin
        // payload request
        left_d = left_q - 32'd1;
        q_push_o = 1'b1;
        q_data_o.last = (left_q == 32'd1);
        if (left_q == 32'd1) begin
          cnt_d = '0;
        end
      end else begin
        case (cnt_q)
          4'd0:  len_d[7:0]    = stream_byte_i;
          4'd1:  len_d[15:8]   = stream_byte_i;
          4'd2:  len_d[23:16]  = stream_byte_i;
          4'd3:  len_d[31:24]  = stream_byte_i;
          4'd4:  main_d[7:0]   = stream_byte_i;
          4'd5:  main_d[15:8]  = stream_byte_i;
          4'd6:  sub_d[7:0]    = stream_byte_i;
          4'd7:  sub_d[15:8]   = stream_byte_i;
          4'd8:  flag_d[7:0]   = stream_byte_i;
          4'd9:  flag_d[15:8]  = stream_byte_i;
          4'd10: flag_d[23:16] = stream_byte_i;
          4'd11: flag_d[31:24] = stream_byte_i;
          default: ;
        endcase
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == PosLenEnd) begin
          if (len_d == 32'd0 || len_d >= {{(32-LimitWidth){1'b0}}, limit_i}) begin
            q_push_o = 1'b1;
            q_data_o.kind = KIND_BAD_LEN;
            q_data_o.last = 1'b1;
            cnt_d = '0;
          end else if (len_d < HdrLen) begin
            q_push_o = 1'b1;
            q_data_o.kind = KIND_SHORT;
            q_data_o.last = 1'b1;
            cnt_d = '0;
          end
        end
        if (cnt_q == PosLast) begin
          if (len_q == HdrLen) begin
            q_push_o = 1'b1;
            q_data_o.kind = KIND_EMPTY;
            q_data_o.last = 1'b1;
            cnt_d = '0;
          end else begin
            left_d = len_q - HdrLen;
          end
        end
      end
    end
    q_data_o.main_id = main_d;
    q_data_o.sub_id  = sub_d;
    q_data_o.flag    = flag_d;
    q_data_o.length  = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      len_q  <= '0;
      main_q <= '0;
      sub_q  <= '0;
      flag_q <= '0;
      left_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      main_q <= main_d;
      sub_q  <= sub_d;
      flag_q <= flag_d;
      left_q <= left_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lppd_fifo.sv -----
`default_nettype none
module lppd_fifo
  import lppd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire res_t                       push_data_i,
  output logic                            ready_o,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output res_t                            pop_data_o,
  output logic [$clog2(Depth+1)-1:0]      count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign ready_o    = (cnt_q != CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign count_o    = cnt_q;
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lppd_back.sv -----
`default_nettype none
module lppd_back
  import lppd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire res_t        q_data_i,
  output logic             q_pop_o,
  output logic             result_valid_o,
  input  wire logic        result_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      main_id_o,
  output logic [15:0]      sub_id_o,
  output logic [31:0]      compress_mark_o,
  output logic [31:0]      packet_length_o,
  output logic             last_o
);

  res_t out_q, out_d;
  logic valid_q;
  logic has_hdr;

  assign q_pop_o = q_valid_i & (~valid_q | result_ready_i);

  always_comb begin
    out_d = q_data_i;
    has_hdr = 1'b1;
    case (q_data_i.kind)
      KIND_PAYLOAD: has_hdr = 1'b1;
      KIND_EMPTY: begin
        has_hdr = 1'b1;
        out_d.data = '0;
      end
      KIND_BAD_LEN, KIND_SHORT: begin
        has_hdr = 1'b0;
        out_d.data = '0;
      end
      default: has_hdr = 1'b0;
    endcase
    if (!has_hdr) begin
      out_d.main_id = '0;
      out_d.sub_id  = '0;
      out_d.flag    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (result_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign result_valid_o  = valid_q;
  assign kind_o          = out_q.kind;
  assign payload_byte_o  = out_q.data;
  assign main_id_o       = out_q.main_id;
  assign sub_id_o        = out_q.sub_id;
  assign compress_mark_o = out_q.flag;
  assign packet_length_o = out_q.length;
  assign last_o          = out_q.last;

endmodule
`default_nettype wire

// ----- hw/rtl/length_prefixed_packet_deframer.sv -----
`default_nettype none
// channel   | valid / enable  | ready          | payload
// stream in | stream_valid_i  | stream_ready_o | stream_byte_i
// result    | result_valid_o  | result_ready_i | kind_o .. last_o
// config    | length_limit_we_i | none         | length_limit_i
//
// one byte request accepted per cycle unless the queue is full
// a result passes the queue, then the output register; output stalls slow the parser
// reset clears the parser, the queue and the output valid; limit returns to 8192
// a stalled output fills the queue; stream_ready_o drops only when it is full
module length_prefixed_packet_deframer
  import lppd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  length_limit_we_i,
  input  wire logic [LimitWidth-1:0] length_limit_i,
  input  wire logic                  stream_valid_i,
  output logic                       stream_ready_o,
  input  wire logic [7:0]            stream_byte_i,
  output logic                       result_valid_o,
  input  wire logic                  result_ready_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 payload_byte_o,
  output logic [15:0]                main_id_o,
  output logic [15:0]                sub_id_o,
  output logic [31:0]                compress_mark_o,
  output logic [31:0]                packet_length_o,
  output logic                       last_o
);

  logic [LimitWidth-1:0] limit_q;
  logic q_ready, q_push, q_valid, q_pop;
  res_t q_in, q_out;
  logic [$clog2(QueueDepth+1)-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (length_limit_we_i) begin
      limit_q <= length_limit_i;
    end
  end

  lppd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stream_valid_i (stream_valid_i),
    .stream_ready_o (stream_ready_o),
    .stream_byte_i  (stream_byte_i),
    .limit_i        (limit_q),
    .q_ready_i      (q_ready),
    .q_push_o       (q_push),
    .q_data_o       (q_in)
  );

  lppd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out),
    .count_o     (q_count)
  );

  lppd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_out),
    .q_pop_o         (q_pop),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .main_id_o       (main_id_o),
    .sub_id_o        (sub_id_o),
    .compress_mark_o (compress_mark_o),
    .packet_length_o (packet_length_o),
    .last_o          (last_o)
  );

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stream_ready_o |-> (q_count == ($clog2(QueueDepth+1))'(QueueDepth)))
    else $error("input stalled while queue not full");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_BAD_LEN || kind_o == KIND_SHORT)
      |-> last_o && main_id_o == '0 && compress_mark_o == '0)
    else $error("error result without last or with header fields");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_EMPTY |-> packet_length_o == HdrLen && last_o)
    else $error("empty packet end with wrong length");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_PAYLOAD |-> packet_length_o > HdrLen)
    else $error("payload byte from a packet without payload");

endmodule
`default_nettype wire
